### hdl/servo_linear_ramp_top_macros.svh
// Assertion helpers used by the servo ramp datapath.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef SERVO_LINEAR_RAMP_TOP_MACROS_SVH
`define SERVO_LINEAR_RAMP_TOP_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define SLR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define SLR_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

### hdl/slr_pkg.sv
package slr_pkg;

    // Field widths.
    localparam int ANGLE_W = 8;
    localparam int DUR_W   = 12;
    localparam int TPS_W22 = 22;

    // Tick rate of the tick items, in ticks per second.
    localparam int TICKS_PER_SECOND = 1000;
    localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
    localparam int PROD_W = DUR_W + TPS_W;
    localparam int CMP_W  = (PROD_W > TPS_W22) ? PROD_W : TPS_W22;
    localparam int DIV_CNT_W = $clog2(PROD_W);

    localparam logic [TPS_W-1:0]   TPS_VAL     = TPS_W'(TICKS_PER_SECOND);
    localparam logic [TPS_W22-1:0] TPS_MAX     = {TPS_W22{1'b1}};
    localparam logic [ANGLE_W-1:0] ANGLE_LIMIT = 8'd180;

    // Operation codes.
    localparam logic OP_MOVE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Register index of max_angle.
    localparam logic REG_MAX_ANGLE = 1'b0;

    typedef struct packed {
        logic               operation;
        logic [ANGLE_W-1:0] target_angle;
        logic [DUR_W-1:0]   duration_seconds;
    } in_item_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic               moving;
        logic               stepped;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_STEP,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;
        logic prep;
        logic div_step;
        logic step;
        logic tick;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_tick;
        logic same;
        logic div_last;
        logic out_free;
    } dp_stat_t;

endpackage

### hdl/slr_ctrl.sv
module slr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  slr_pkg::dp_stat_t stat,
    output slr_pkg::ctrl_cmd_t cmd
);
    import slr_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (stat.is_tick)
                begin
                    cmd.tick   = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.prep   = 1'b1;
                    state_next = stat.same ? ST_OUT : ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/slr_dp.sv
`include "servo_linear_ramp_top_macros.svh"

module slr_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  slr_pkg::ctrl_cmd_t          cmd,
    output slr_pkg::dp_stat_t           stat,
    input  slr_pkg::in_item_t           cmd_data,
    input  logic [slr_pkg::ANGLE_W-1:0] max_angle,
    output logic                        res_valid,
    input  logic                        res_ready,
    output slr_pkg::out_item_t          res_data
);
    import slr_pkg::*;

    // Latched input item.
    logic               op_reg;
    logic [ANGLE_W-1:0] tgt_reg;
    logic [DUR_W-1:0]   dur_reg;

    // Ramp state.
    logic [ANGLE_W-1:0] position_reg;
    logic [ANGLE_W-1:0] goal_reg;
    logic [TPS_W22-1:0] tps_reg;
    logic [TPS_W22-1:0] tick_count_reg;
    logic               busy_reg;
    logic               stepped_reg;

    // Divider.
    logic [PROD_W-1:0]    quo_reg;
    logic [ANGLE_W-1:0]   rem_reg;
    logic [ANGLE_W-1:0]   dist_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    // Result register.
    logic      out_valid_reg;
    out_item_t out_data_reg;

    logic [ANGLE_W-1:0] lim;
    logic [ANGLE_W-1:0] clamped;
    logic [ANGLE_W:0]   trial;
    logic               trial_ge;
    logic [CMP_W-1:0]   q_ext;
    logic [TPS_W22-1:0] q_sat;
    logic [TPS_W22-1:0] tc_inc;
    logic [ANGLE_W-1:0] pos_stepped;
    logic               can_step;

    // Target clamp against the configured limit.
    always_comb
    begin
        lim     = (max_angle > ANGLE_LIMIT) ? ANGLE_LIMIT : max_angle;
        clamped = (tgt_reg > lim) ? lim : tgt_reg;
    end

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[PROD_W-1]};
        trial_ge = (trial >= {1'b0, dist_reg});
    end

    // Quotient with a floor of one and saturation to the interval width.
    always_comb
    begin
        q_ext = CMP_W'(quo_reg);
        if (q_ext == '0)
        begin
            q_sat = TPS_W22'(1);
        end
        else if (q_ext > CMP_W'(TPS_MAX))
        begin
            q_sat = TPS_MAX;
        end
        else
        begin
            q_sat = TPS_W22'(q_ext);
        end
    end

    // One-degree move toward the goal.
    always_comb
    begin
        can_step = (position_reg != goal_reg);
        if (position_reg < goal_reg)
        begin
            pos_stepped = position_reg + ANGLE_W'(1);
        end
        else if (position_reg > goal_reg)
        begin
            pos_stepped = position_reg - ANGLE_W'(1);
        end
        else
        begin
            pos_stepped = position_reg;
        end
        tc_inc = tick_count_reg + TPS_W22'(1);
    end

    // Input latch and divider registers; no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg  <= cmd_data.operation;
            tgt_reg <= cmd_data.target_angle;
            dur_reg <= cmd_data.duration_seconds;
        end
        if (cmd.prep)
        begin
            quo_reg     <= PROD_W'(dur_reg) * PROD_W'(TPS_VAL);
            rem_reg     <= '0;
            div_cnt_reg <= '0;
            dist_reg    <= (clamped > position_reg) ? (clamped - position_reg)
                                                    : (position_reg - clamped);
        end
        else if (cmd.div_step)
        begin
            quo_reg     <= {quo_reg[PROD_W-2:0], trial_ge};
            rem_reg     <= trial_ge ? ANGLE_W'(trial - {1'b0, dist_reg})
                                    : ANGLE_W'(trial);
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    // Ramp state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            goal_reg       <= '0;
            tps_reg        <= TPS_W22'(1);
            tick_count_reg <= '0;
            busy_reg       <= 1'b0;
            stepped_reg    <= 1'b0;
        end
        else if (cmd.prep)
        begin
            // A new command restarts the ramp from the current angle.
            goal_reg       <= clamped;
            tick_count_reg <= '0;
            stepped_reg    <= 1'b0;
            if (clamped == position_reg)
            begin
                busy_reg <= 1'b0;
            end
        end
        else if (cmd.step)
        begin
            // The first step of a move is taken on the command item itself.
            tps_reg        <= q_sat;
            position_reg   <= pos_stepped;
            busy_reg       <= (pos_stepped != goal_reg);
            stepped_reg    <= can_step;
            tick_count_reg <= '0;
        end
        else if (cmd.tick)
        begin
            stepped_reg <= 1'b0;
            if (busy_reg)
            begin
                if (tc_inc >= tps_reg)
                begin
                    tick_count_reg <= '0;
                    position_reg   <= pos_stepped;
                    busy_reg       <= can_step && (pos_stepped != goal_reg);
                    stepped_reg    <= can_step;
                end
                else
                begin
                    tick_count_reg <= tc_inc;
                end
            end
            else
            begin
                tick_count_reg <= '0;
            end
        end
    end

    // Result register parts the datapath from a stalled receiver.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg.angle   <= position_reg;
            out_data_reg.moving  <= busy_reg;
            out_data_reg.stepped <= stepped_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

    // Status to the controller.
    always_comb
    begin
        stat.is_tick  = (op_reg == OP_TICK);
        stat.same     = (clamped == position_reg);
        stat.div_last = (div_cnt_reg == DIV_CNT_W'(PROD_W - 1));
        stat.out_free = !out_valid_reg || res_ready;
    end

    `SLR_ASSERT_ALWAYS(a_tps_nonzero, tps_reg != '0, "ticks per step is zero")
    `SLR_ASSERT_ALWAYS(a_idle_count_clear, busy_reg || (tick_count_reg == '0),
        "tick count not clear while idle")
    `SLR_ASSERT_ALWAYS(a_count_below_interval, tick_count_reg < tps_reg,
        "tick count reached the interval without a step")
    `SLR_ASSERT_NEXT(a_cmd_step_moves, cmd.step, position_reg != $past(position_reg),
        "command step left the angle unchanged")

endmodule

### hdl/servo_linear_ramp_top.sv
// Servo linear ramp: moves a servo angle toward a commanded target in
// one-degree steps spread evenly over a commanded duration.
// Input channel cmd_valid/cmd_ready/cmd_data carries either a move command
// (target angle and duration in seconds) or a one-millisecond tick item.
// Each accepted item yields exactly one result on res_valid/res_ready/res_data:
// the angle after the item, whether the ramp is still moving, and whether the
// angle stepped on this item.
// Path: a tick item or a command to the current angle goes from IDLE through
// PREP to OUT, where the result register loads; any other command also passes
// through DIV, the restoring divider that works out ticks per step one quotient
// bit per cycle, and then STEP. Items are taken one at a time: the next item is
// accepted only once the block is back in IDLE.
// A result register sits at the output: the next item is accepted while a
// result waits, and if the receiver stalls the following result holds inside
// the block until the register frees, with cmd_ready low meanwhile.
// Reset clears the angle, goal and tick count to zero, sets the interval to
// one tick and max_angle to 180. max_angle lies at APB byte address 0.
module servo_linear_ramp_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  slr_pkg::in_item_t  cmd_data,
    output logic               res_valid,
    input  logic               res_ready,
    output slr_pkg::out_item_t res_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import slr_pkg::*;

    logic [ANGLE_W-1:0] max_angle_reg;
    ctrl_cmd_t          cmd;
    dp_stat_t           stat;
    logic               apb_write;

    // Configuration register.
    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_angle_reg <= ANGLE_LIMIT;
        end
        else if (apb_write && (paddr[2] == REG_MAX_ANGLE))
        begin
            max_angle_reg <= pwdata[ANGLE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_MAX_ANGLE)
        begin
            prdata = 32'(max_angle_reg);
        end
    end

    // Controller and datapath.
    slr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    slr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cmd_data  (cmd_data),
        .max_angle (max_angle_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule
